@@ hdl/bitmap_page_allocator_core_macros.svh @@
// Assertion macros for the page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bpa_pkg.sv @@
// Types and constants shared by the bitmap page allocator modules.
`default_nettype none

package bpa_pkg;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_P2A   = 2'd2,
        ACT_A2P   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESULT
    } eng_state_t;

    typedef struct packed {
        logic [31:0] value;
        logic        no_free;
    } result_t;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 1'd1;

    localparam logic [15:0] RESET_PAGE_COUNT = 16'd32768;
    localparam logic [31:0] FAIL_VALUE       = 32'hFFFF_FFFF;
    localparam logic [7:0]  INIT_MAP_BYTE    = 8'h01;
    localparam logic [7:0]  FULL_MAP_BYTE    = 8'hFF;

endpackage

`default_nettype wire

@@ hdl/bpa_map_ram.sv @@
// Used-map memory: one write port, one read port, registered read data.
`default_nettype none

module bpa_map_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/bpa_engine.sv @@
// Request sequencer: map scan, map update and address conversions.
`default_nettype none
`include "bitmap_page_allocator_core_macros.svh"

module bpa_engine #(
    parameter int unsigned MAX_PAGES  = 32768,
    parameter int unsigned PAGE_BYTES = 4096,
    parameter int unsigned MAP_BYTES  = (MAX_PAGES + 7) / 8,
    parameter int unsigned MAP_AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bpa_pkg::action_t  action,
    input  wire logic [31:0]       page_number,
    input  wire logic [31:0]       byte_address,
    input  wire logic [31:0]       region_base,
    input  wire logic [15:0]       page_count,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output bpa_pkg::result_t       res,
    output logic                   mem_rd_en,
    output logic [MAP_AW-1:0]      mem_rd_addr,
    input  wire logic [7:0]        mem_rd_data,
    output logic                   mem_wr_en,
    output logic [MAP_AW-1:0]      mem_wr_addr,
    output logic [7:0]             mem_wr_data
);

    localparam int unsigned CW    = $clog2(MAP_BYTES + 1);
    localparam int unsigned PB_SH = $clog2(PAGE_BYTES);
    localparam logic [31:0] MAX_PAGES_W = 32'(MAX_PAGES);

    bpa_pkg::eng_state_t state_reg, state_next;
    logic [CW-1:0]       b_reg, b_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [MAP_AW-1:0]   last_byte_reg, last_byte_next;
    logic [31:0]         value_reg, value_next;
    logic                fail_reg, fail_next;

    logic [31:0]         limit;
    logic [CW-1:0]       bytes_lim;
    logic [7:0]          map_byte;
    logic [2:0]          bit_idx;

    // Search bound in whole bytes, page count saturated to the map size.
    always_comb
    begin
        limit     = (32'(page_count) > MAX_PAGES_W) ? MAX_PAGES_W : 32'(page_count);
        bytes_lim = limit[CW+2:3];
    end

    // Bytes at or above the high-water mark were never written since the last clear.
    always_comb
    begin
        map_byte = (b_reg >= fill_reg) ? 8'h00 : mem_rd_data;
        bit_idx  = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!map_byte[i])
            begin
                bit_idx = 3'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::ST_IDLE;
            fill_reg      <= '0;
            last_byte_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            last_byte_reg <= last_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        value_reg <= value_next;
        fail_reg  <= fail_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        b_next         = b_reg;
        fill_next      = fill_reg;
        last_byte_next = last_byte_reg;
        value_next     = value_reg;
        fail_next      = fail_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = b_reg[MAP_AW-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = b_reg[MAP_AW-1:0];
        mem_wr_data    = map_byte | (8'h01 << bit_idx);

        case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    fail_next = 1'b0;
                    case (action)
                        bpa_pkg::ACT_INIT:
                        begin
                            // Drop the old map by resetting the mark; byte 0 holds page 0.
                            mem_wr_en      = 1'b1;
                            mem_wr_addr    = '0;
                            mem_wr_data    = bpa_pkg::INIT_MAP_BYTE;
                            fill_next      = CW'(1);
                            last_byte_next = '0;
                            value_next     = '0;
                            state_next     = bpa_pkg::ST_RESULT;
                        end
                        bpa_pkg::ACT_ALLOC:
                        begin
                            b_next     = CW'(last_byte_reg);
                            state_next = bpa_pkg::ST_READ;
                        end
                        bpa_pkg::ACT_P2A:
                        begin
                            value_next = region_base + (page_number << PB_SH);
                            state_next = bpa_pkg::ST_RESULT;
                        end
                        bpa_pkg::ACT_A2P:
                        begin
                            value_next = (byte_address - region_base) >> PB_SH;
                            state_next = bpa_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            state_next = bpa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bpa_pkg::ST_READ:
            begin
                if (b_reg >= bytes_lim)
                begin
                    value_next = bpa_pkg::FAIL_VALUE;
                    fail_next  = 1'b1;
                    state_next = bpa_pkg::ST_RESULT;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = bpa_pkg::ST_CHECK;
                end
            end
            bpa_pkg::ST_CHECK:
            begin
                if (map_byte != bpa_pkg::FULL_MAP_BYTE)
                begin
                    mem_wr_en      = 1'b1;
                    last_byte_next = b_reg[MAP_AW-1:0];
                    if (b_reg >= fill_reg)
                    begin
                        fill_next = b_reg + CW'(1);
                    end
                    value_next = region_base
                               + (32'({b_reg[MAP_AW-1:0], bit_idx}) << PB_SH);
                    state_next = bpa_pkg::ST_RESULT;
                end
                else
                begin
                    b_next     = b_reg + CW'(1);
                    state_next = bpa_pkg::ST_READ;
                end
            end
            bpa_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.value   = value_reg;
    assign res.no_free = fail_reg;

    `BPA_ASSERT_IMP(a_no_rw_overlap, mem_wr_en, !mem_rd_en, "map read and write in one cycle")
    `BPA_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(MAP_BYTES), "fill mark past map end")
    `BPA_ASSERT_NEXT(a_read_then_check, (state_reg == bpa_pkg::ST_READ) && (b_reg < bytes_lim),
        state_reg == bpa_pkg::ST_CHECK, "map read not followed by check")
    `BPA_ASSERT_IMP(a_fail_code, res_valid && res.no_free,
        res.value == bpa_pkg::FAIL_VALUE, "failed allocation without failure code")

endmodule

`default_nettype wire

@@ hdl/bpa_out_buf.sv @@
// Two-entry result buffer with a registered output and a skid entry.
`default_nettype none

module bpa_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bpa_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bpa_pkg::result_t      out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    bpa_pkg::result_t out_data_reg;
    bpa_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            // Advance the skid entry first; it always holds the older result.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bitmap_page_allocator_core.sv @@
// Top level of the next-fit bitmap page allocator.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tuser: action; tdata: page_number, byte_address
//  m_*      out  m_tvalid/m_tready  tdata: result_value; tuser: no_free_page
//  cfg_*    in   cfg_valid/cfg_ready cfg_index: register, cfg_data: value
//
// Initialize and the two conversions go from idle straight to the result state.
// Allocate passes through a read and a check state for each map byte it checks, and
// through one more read state when the scan reaches the search bound.
// The map is cleared by a high-water mark, so reset and initialize need no sweep.
// A result buffer of two entries lets a request run while a result is stalled.
// Reset is asynchronous, active low; config holds region_base 0, page_count 32768.
`default_nettype none

module bitmap_page_allocator_core #(
    parameter int unsigned MAX_PAGES  = 32768,
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,   // page_number, byte_address
    input  wire logic [1:0]                    s_tuser,   // action
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // result_value
    output logic [0:0]                         m_tuser,   // no_free_page
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    // Map size follows from the page limit; PAGE_BYTES must be a power of two.
    localparam int unsigned MAP_BYTES = (MAX_PAGES + 7) / 8;
    localparam int unsigned MAP_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic [31:0]       region_base_reg;
    logic [15:0]       page_count_reg;

    logic              res_valid;
    logic              res_ready;
    bpa_pkg::result_t  res;
    bpa_pkg::result_t  out_res;

    logic              mem_rd_en;
    logic [MAP_AW-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;
    logic              mem_wr_en;
    logic [MAP_AW-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;

    // Config writes are always taken; the sender must issue them only with no request in flight, unchecked here.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            page_count_reg  <= bpa_pkg::RESET_PAGE_COUNT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpa_pkg::CFG_REGION_BASE: region_base_reg <= cfg_data;
                bpa_pkg::CFG_PAGE_COUNT:  page_count_reg  <= cfg_data[15:0];
                default:                  region_base_reg <= region_base_reg;
            endcase
        end
    end

    // Sequencer: decode the request, scan the map, build the result.
    bpa_engine #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .MAP_BYTES  (MAP_BYTES),
        .MAP_AW     (MAP_AW)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .action       (bpa_pkg::action_t'(s_tuser)),
        .page_number  (s_tdata[31:0]),
        .byte_address (s_tdata[63:32]),
        .region_base  (region_base_reg),
        .page_count   (page_count_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data)
    );

    // Used map, one bit per page, eight pages per entry.
    bpa_map_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (MAP_AW)
    ) u_map_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Hold results here so the sequencer can move on while the sink stalls.
    bpa_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata    = out_res.value;
    assign m_tuser[0] = out_res.no_free;

endmodule

`default_nettype wire

@@ test/bitmap_page_allocator_core_tb.sv @@
// Self-checking testbench for the next-fit bitmap page allocator core.
`timescale 1ns / 1ps

module bitmap_page_allocator_core_tb;

    localparam int unsigned MAX_PAGES   = 32768;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned MAP_BYTES   = MAX_PAGES / 8;
    localparam int unsigned SETTLE      = 8;     // idle cycles before a register write
    localparam int unsigned HOLD_AT     = 10;    // results seen before the long output stall
    localparam int unsigned HOLD_LEN    = 300;   // length of the long output stall
    localparam int unsigned STUCK_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int unsigned END_WAIT    = 20;
    localparam int unsigned FILL_PAGES  = 64;    // page count for the final fill

    typedef enum logic {
        ENT_REQ,
        ENT_CFG
    } entry_kind_t;

    typedef struct {
        entry_kind_t                   kind;
        bpa_pkg::action_t              act;
        logic [31:0]                   page;
        logic [31:0]                   addr;
        logic [bpa_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [31:0]                   reg_val;
    } pending_t;

    // DUT pins; every input starts at a known value
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [63:0]                   s_tdata   = '0;    // page_number, byte_address
    logic [1:0]                    s_tuser   = '0;    // action
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [31:0]                   m_tdata;           // result_value
    logic [0:0]                    m_tuser;           // no_free_page
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;

    // Stimulus and scoreboard
    pending_t          pending_q[$];
    bpa_pkg::result_t  awaited_results[$];
    int unsigned sent_cnt       = 0;
    int unsigned recv_cnt       = 0;
    int unsigned calm_from      = 0;
    int unsigned fail_cnt       = 0;
    int unsigned alloc_cnt      = 0;
    int unsigned alloc_fail_cnt = 0;
    int unsigned write_cnt      = 0;
    logic [31:0] cyc            = '0;

    // Allocator image: used map, next-fit cursor and the two registers
    logic [7:0]  map_img [MAP_BYTES];
    logic [14:0] last_pg    = '0;
    logic [31:0] base_reg   = '0;
    logic [15:0] pcount_reg = bpa_pkg::RESET_PAGE_COUNT;

    bitmap_page_allocator_core #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (1 << PAGE_SHIFT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // Update the allocator image for one accepted request and queue its result.
    task automatic track_request(input bpa_pkg::action_t act, input logic [31:0] pg,
                                 input logic [31:0] ad);
        bpa_pkg::result_t r;
        int unsigned      bound;
        int unsigned      b;
        logic             hit;
        r   = '0;
        hit = 1'b0;
        case (act)
            bpa_pkg::ACT_INIT:
            begin
                foreach (map_img[k])
                    map_img[k] = 8'h00;
                map_img[0][0] = 1'b1;
                last_pg = '0;
            end
            bpa_pkg::ACT_ALLOC:
            begin
                alloc_cnt++;
                // clamp the search bound to the map; partial bytes are never searched
                bound = (pcount_reg > MAX_PAGES) ? MAX_PAGES : pcount_reg;
                for (b = last_pg / 8; b < bound / 8 && !hit; b++)
                    for (int i = 0; i < 8 && !hit; i++)
                        if (!map_img[b][i])
                        begin
                            map_img[b][i] = 1'b1;
                            last_pg       = 15'(b * 8 + i);
                            r.value       = base_reg + (32'(b * 8 + i) << PAGE_SHIFT);
                            hit           = 1'b1;
                        end
                if (!hit)
                begin
                    r.value   = bpa_pkg::FAIL_VALUE;
                    r.no_free = 1'b1;
                    alloc_fail_cnt++;
                end
            end
            bpa_pkg::ACT_P2A:
                r.value = base_reg + (pg << PAGE_SHIFT);
            default:
                r.value = (ad - base_reg) >> PAGE_SHIFT;
        endcase
        awaited_results.push_back(r);
    endtask

    task automatic track_write(input logic [bpa_pkg::CFG_IDX_W-1:0] idx,
                               input logic [31:0] val);
        write_cnt++;
        if (idx == bpa_pkg::CFG_REGION_BASE)
            base_reg = val;
        else if (idx == bpa_pkg::CFG_PAGE_COUNT)
            pcount_reg = val[15:0];
    endtask

    task automatic add_request(input bpa_pkg::action_t act, input logic [31:0] pg,
                               input logic [31:0] ad);
        pending_t e;
        e.kind    = ENT_REQ;
        e.act     = act;
        e.page    = pg;
        e.addr    = ad;
        e.reg_idx = '0;
        e.reg_val = '0;
        pending_q.push_back(e);
    endtask

    task automatic add_write(input logic [bpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        pending_t e;
        e.kind    = ENT_CFG;
        e.act     = bpa_pkg::ACT_INIT;
        e.page    = '0;
        e.addr    = '0;
        e.reg_idx = idx;
        e.reg_val = val;
        pending_q.push_back(e);
    endtask

    // ------------------------------------------------------------------
    // Request driver: feed requests and register writes from pending_q.
    // Hold a register write until the block has drained and its quiet count
    // reaches SETTLE; that also gives the sender a full pause each phase.
    // Predict at the edge where the handshake completes.
    // ------------------------------------------------------------------
    int unsigned gap_left = 0;
    int unsigned quiet    = 0;
    logic        sender_may_idle;

    assign sender_may_idle = (sent_cnt < calm_from) && cyc[8];

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left  <= 0;
            quiet     <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_request(bpa_pkg::action_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
                sent_cnt <= sent_cnt + 1;
            end
            if (cfg_valid && cfg_ready)
                track_write(cfg_index, cfg_data);

            // count cycles with nothing offered and nothing outstanding
            if (!s_tvalid && !cfg_valid && sent_cnt == recv_cnt)
                quiet <= quiet + 1;
            else
                quiet <= 0;

            // advance only once both channels are free
            if ((!s_tvalid || s_tready) && (!cfg_valid || cfg_ready))
            begin
                if (gap_left != 0)
                begin
                    s_tvalid  <= 1'b0;
                    cfg_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end
                else if (pending_q.size() == 0)
                begin
                    s_tvalid  <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending_q[0].kind == ENT_CFG)
                begin
                    s_tvalid <= 1'b0;
                    if (quiet >= SETTLE && !s_tvalid && !cfg_valid && sent_cnt == recv_cnt)
                    begin
                        cfg_valid <= 1'b1;
                        cfg_index <= pending_q[0].reg_idx;
                        cfg_data  <= pending_q[0].reg_val;
                        void'(pending_q.pop_front());
                    end
                    else
                        cfg_valid <= 1'b0;
                end
                else
                begin
                    s_tvalid  <= 1'b1;
                    s_tuser   <= pending_q[0].act;
                    s_tdata   <= {pending_q[0].addr, pending_q[0].page};
                    cfg_valid <= 1'b0;
                    void'(pending_q.pop_front());
                    // idle for a burst once this request is taken
                    if (sender_may_idle && $urandom_range(0, 5) == 0)
                        gap_left <= $urandom_range(1, 16);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stall bursts, plus one long hold-off that lets
    // the result buffer fill so the block has to stall its input side.
    // The hold-off starts inside the first init-and-allocate run, so the
    // sender still has requests to offer while it lasts.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && recv_cnt >= HOLD_AT)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (recv_cnt < calm_from && !cyc[7] && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        bpa_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            recv_cnt <= recv_cnt + 1;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result expected none, got value=%h no_free_page=%b",
                         $time, m_tdata, m_tuser[0]);
                fail_cnt++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata !== want.value)
                begin
                    $display("%0t: result_value expected %h, got %h",
                             $time, want.value, m_tdata);
                    fail_cnt++;
                end
                if (m_tuser[0] !== want.no_free)
                begin
                    $display("%0t: no_free_page expected %b, got %b",
                             $time, want.no_free, m_tuser[0]);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: drop the run when no handshake of any kind happens for too long.
    int unsigned stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: nothing moved for %0d cycles", $time, STUCK_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [31:0] gen_base;
        int unsigned n_req;
        int unsigned n_phase;
        int unsigned pick;

        foreach (map_img[k])
            map_img[k] = 8'h00;

        // At reset values: allocate from an untouched map, then the conversions
        // at the ends of their ranges.
        add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);
        add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);
        add_request(bpa_pkg::ACT_P2A, 32'h0000_0000, $urandom);
        add_request(bpa_pkg::ACT_P2A, 32'hFFFF_FFFF, $urandom);
        add_request(bpa_pkg::ACT_P2A, 32'h0008_0001, $urandom);
        add_request(bpa_pkg::ACT_A2P, $urandom, 32'h0000_0000);
        add_request(bpa_pkg::ACT_A2P, $urandom, 32'hFFFF_FFFF);
        add_request(bpa_pkg::ACT_A2P, $urandom, 32'h0000_1FFF);

        // Base chosen so page 1 lands on the failure code; one byte of pages,
        // filled until the allocation runs dry.
        add_write(bpa_pkg::CFG_REGION_BASE, 32'hFFFF_EFFF);
        add_write(bpa_pkg::CFG_PAGE_COUNT, 32'd8);
        add_request(bpa_pkg::ACT_INIT, $urandom, $urandom);
        add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);
        add_request(bpa_pkg::ACT_A2P, $urandom, 32'hFFFF_FFFF);
        repeat (7)
            add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);

        // Fewer than eight pages: nothing to search.
        add_write(bpa_pkg::CFG_PAGE_COUNT, 32'd7);
        add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);

        // Zero pages, top base: allocation fails, conversion wraps.
        add_write(bpa_pkg::CFG_PAGE_COUNT, 32'd0);
        add_write(bpa_pkg::CFG_REGION_BASE, 32'hFFFF_FFFF);
        add_request(bpa_pkg::ACT_INIT, $urandom, $urandom);
        add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);
        add_request(bpa_pkg::ACT_P2A, 32'd1, $urandom);

        // Page count past the map, with junk above bit 15 of the write.
        add_write(bpa_pkg::CFG_PAGE_COUNT, {16'($urandom_range(0, 16'hFFFF)), 16'hFFFF});
        add_write(bpa_pkg::CFG_REGION_BASE, 32'h0000_0000);
        add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);
        n_req    = 23;
        gen_base = '0;

        // Random phases: new settings, then mostly init-and-allocate runs
        // with conversions and a few stray inits mixed in.
        for (n_phase = 0; n_phase < 8; n_phase++)
        begin
            pick = $urandom_range(0, 3);
            if (pick != 1)
            begin
                case ($urandom_range(0, 4))
                    0:       gen_base = 32'h0000_0000;
                    1:       gen_base = 32'hFFFF_FFFF;
                    2:       gen_base = 32'hFFFF_F000;
                    default: gen_base = $urandom;
                endcase
                add_write(bpa_pkg::CFG_REGION_BASE, gen_base);
            end
            if (pick != 2)
            begin
                case ($urandom_range(0, 7))
                    0:       add_write(bpa_pkg::CFG_PAGE_COUNT, 32'd0);
                    1:       add_write(bpa_pkg::CFG_PAGE_COUNT, $urandom_range(1, 7));
                    2:       add_write(bpa_pkg::CFG_PAGE_COUNT, 32'd8);
                    3:       add_write(bpa_pkg::CFG_PAGE_COUNT, $urandom_range(9, 64));
                    4:       add_write(bpa_pkg::CFG_PAGE_COUNT, $urandom_range(65, 512));
                    5:       add_write(bpa_pkg::CFG_PAGE_COUNT, 32'd32768);
                    6:       add_write(bpa_pkg::CFG_PAGE_COUNT, $urandom_range(32769, 65535));
                    default: add_write(bpa_pkg::CFG_PAGE_COUNT, $urandom);
                endcase
            end
            if ($urandom_range(0, 3) != 0)
            begin
                add_request(bpa_pkg::ACT_INIT, $urandom, $urandom);
                n_req++;
            end
            repeat ($urandom_range(30, 46))
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                    add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);
                else if (pick <= 7)
                    add_request(bpa_pkg::ACT_P2A,
                                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40000),
                                $urandom);
                else if (pick == 8)
                    add_request(bpa_pkg::ACT_A2P, $urandom,
                                $urandom_range(0, 1) ? $urandom
                                                     : gen_base + $urandom_range(0, 1 << 20));
                else
                    add_request(bpa_pkg::ACT_INIT, $urandom, $urandom);
                n_req++;
            end
        end

        // Last stretch, no idling on either side: fill every page below a
        // small page count, then run past the end.
        calm_from = n_req;
        add_write(bpa_pkg::CFG_PAGE_COUNT, FILL_PAGES);
        add_write(bpa_pkg::CFG_REGION_BASE, $urandom);
        add_request(bpa_pkg::ACT_INIT, $urandom, $urandom);
        repeat (FILL_PAGES + 1)
            add_request(bpa_pkg::ACT_ALLOC, $urandom, $urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the queue to empty and every result to come back.
        while (pending_q.size() != 0 || s_tvalid || cfg_valid || sent_cnt != recv_cnt)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (awaited_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, awaited_results.size());

        $display("Ran %0d requests (%0d allocations, %0d with no free page) and %0d writes;",
                 sent_cnt, alloc_cnt, alloc_fail_cnt, write_cnt);
        $display("wrapped bases, tiny and oversized page counts, a long stall, a filled map.");
        if (fail_cnt == 0 && awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ bitmap_page_allocator_core.f @@
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_map_ram.sv
hdl/bpa_engine.sv
hdl/bpa_out_buf.sv
hdl/bitmap_page_allocator_core.sv
test/bitmap_page_allocator_core_tb.sv
